/* sv/mrfa_pkg.sv */
// ----------------------------------------------------------------------------
// mrfa_pkg
// Shared types, register codes and helpers of the multicast rate feedback agent.
// ----------------------------------------------------------------------------
package mrfa_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IN_W   = 88;

  localparam logic [2:0] REG_GROUP_ADDR = 3'd0;
  localparam logic [2:0] REG_OWN_ID     = 3'd1;
  localparam logic [2:0] REG_FB_THR     = 3'd2;
  localparam logic [2:0] REG_ACK_THR    = 3'd3;
  localparam logic [2:0] REG_ACK_PORT   = 3'd4;

  localparam logic [31:0] RST_GROUP_ADDR = 32'hE0004343;
  localparam logic [2:0]  RST_OWN_ID     = 3'd3;
  localparam logic [15:0] RST_FB_THR     = 16'd40;
  localparam logic [15:0] RST_ACK_THR    = 16'd10;
  localparam logic [15:0] RST_ACK_PORT   = 16'd1532;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  localparam logic [4:0]  CODE_BASE     = 5'd4;
  localparam logic [31:0] TAKEOVER_MARK = 32'd99;

  typedef struct packed {
    logic [31:0] group_address;
    logic [2:0]  own_id;
    logic [15:0] feedback_threshold;
    logic [15:0] ack_threshold;
    logic [15:0] ack_port;
  } cfg_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* sv/mrfa_ram.sv */
// ----------------------------------------------------------------------------
// mrfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/mrfa_cfg.sv */
// ----------------------------------------------------------------------------
// mrfa_cfg
// APB register file: group address, own id, thresholds and ack port.
// ----------------------------------------------------------------------------
module mrfa_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrfa_pkg::ADDR_W-1:0] paddr,
  input  logic [mrfa_pkg::DATA_W-1:0] pwdata,
  output logic [mrfa_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mrfa_pkg::cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_address      <= mrfa_pkg::RST_GROUP_ADDR;
      cfg.own_id             <= mrfa_pkg::RST_OWN_ID;
      cfg.feedback_threshold <= mrfa_pkg::RST_FB_THR;
      cfg.ack_threshold      <= mrfa_pkg::RST_ACK_THR;
      cfg.ack_port           <= mrfa_pkg::RST_ACK_PORT;
    end else if (wr) begin
      unique case (idx)
        mrfa_pkg::REG_GROUP_ADDR: cfg.group_address      <= pwdata;
        mrfa_pkg::REG_OWN_ID:     cfg.own_id             <= pwdata[2:0];
        mrfa_pkg::REG_FB_THR:     cfg.feedback_threshold <= pwdata[15:0];
        mrfa_pkg::REG_ACK_THR:    cfg.ack_threshold      <= pwdata[15:0];
        mrfa_pkg::REG_ACK_PORT:   cfg.ack_port           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mrfa_pkg::REG_GROUP_ADDR: prdata = cfg.group_address;
      mrfa_pkg::REG_OWN_ID:     prdata = {29'd0, cfg.own_id};
      mrfa_pkg::REG_FB_THR:     prdata = {16'd0, cfg.feedback_threshold};
      mrfa_pkg::REG_ACK_THR:    prdata = {16'd0, cfg.ack_threshold};
      mrfa_pkg::REG_ACK_PORT:   prdata = {16'd0, cfg.ack_port};
      default:                  prdata = '0;
    endcase
  end

endmodule

/* sv/mrfa_ctrl.sv */
// ----------------------------------------------------------------------------
// mrfa_ctrl
// Packet sorter, counters, bin read-modify-write and report sequencer.
// ----------------------------------------------------------------------------
module mrfa_ctrl #(
  parameter int NUM_BINS = 12,
  parameter int IDX_W    = $clog2(NUM_BINS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mrfa_pkg::cfg_t             cfg,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mrfa_pkg::IN_W-1:0]  s_tdata,
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast,
  output logic                       ram_wr_en,
  output logic [IDX_W-1:0]           ram_wr_addr,
  output logic [31:0]                ram_wr_data,
  output logic                       ram_rd_en,
  output logic [IDX_W-1:0]           ram_rd_addr,
  input  logic [31:0]                ram_rd_data
);

  localparam int POS_W = $clog2(NUM_BINS + 1);
  localparam logic [POS_W-1:0] POS_LIM  = POS_W'(NUM_BINS);
  localparam logic [4:0]       BIN_LIM  = 5'(NUM_BINS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BINS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BIN    = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0]          state;
  logic [POS_W-1:0]    word_pos;
  logic [1:0]          pkt_kind;
  logic [31:0]         packet_count;
  logic [31:0]         ack_count;
  logic [31:0]         received_sum;
  logic [2:0]          current_leader;
  logic [NUM_BINS-1:0] bin_valid;
  logic [IDX_W-1:0]    upd_addr;
  logic                fb_pend;
  logic                rep_kind;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    rd_idx_q;
  logic                rd_pend;
  logic                rd_all;
  logic                rd_vld;

  logic [31:0] dest_addr;
  logic [15:0] dest_port;
  logic [7:0]  ttl;
  logic [31:0] payload_word;
  logic        acc;
  logic        first;
  logic        is_ack;
  logic [1:0]  kind_now;
  logic [4:0]  code_off;
  logic [3:0]  bin_raw;
  logic        bin_ok;
  logic [31:0] cnt_inc;
  logic [2:0]  leader_new;
  logic        fb_hit;
  logic        data_start;
  logic        ack_word;
  logic        sum_add;
  logic [35:0] cnt_x10;
  logic [35:0] sum_x9;
  logic        take_hit;
  logic        rd_issue;
  logic [31:0] bin_cur;

  assign dest_addr    = s_tdata[31:0];
  assign dest_port    = s_tdata[47:32];
  assign ttl          = s_tdata[55:48];
  assign payload_word = s_tdata[87:56];

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign first    = (word_pos == '0);
  assign is_ack   = (dest_port == cfg.ack_port) && (current_leader != cfg.own_id) &&
                    (current_leader != 3'd0);

  always_comb begin
    if (!first) begin
      kind_now = pkt_kind;
    end else if (dest_addr != cfg.group_address) begin
      kind_now = mrfa_pkg::KIND_NONE;
    end else if (is_ack) begin
      kind_now = mrfa_pkg::KIND_ACK;
    end else begin
      kind_now = mrfa_pkg::KIND_DATA;
    end
  end

  assign code_off   = ttl[4:0] - mrfa_pkg::CODE_BASE;
  assign bin_raw    = code_off[4:1];
  assign bin_ok     = (ttl[4:0] >= mrfa_pkg::CODE_BASE) && ({1'b0, bin_raw} < BIN_LIM);
  assign cnt_inc    = mrfa_pkg::sat_add(packet_count, 32'd1);
  assign leader_new = ttl[7:5];
  assign fb_hit     = (cnt_inc > {16'd0, cfg.feedback_threshold}) &&
                      ((leader_new == cfg.own_id) || (leader_new == 3'd0));
  assign data_start = acc && first && (kind_now == mrfa_pkg::KIND_DATA);
  assign ack_word   = acc && (kind_now == mrfa_pkg::KIND_ACK);
  assign sum_add    = ack_word && (word_pos < POS_LIM);

  assign cnt_x10  = {1'b0, packet_count, 3'b000} + {3'b000, packet_count, 1'b0};
  assign sum_x9   = {1'b0, received_sum, 3'b000} + {4'b0000, received_sum};
  assign take_hit = (ack_count >= {16'd0, cfg.ack_threshold}) && (cnt_x10 < sum_x9);

  assign rd_issue = (state == ST_REPORT) && !rd_pend && !rd_all && (!m_tvalid || m_tready);

  assign bin_cur     = bin_valid[upd_addr] ? ram_rd_data : 32'd0;
  assign ram_wr_en   = (state == ST_BIN);
  assign ram_wr_addr = upd_addr;
  assign ram_wr_data = mrfa_pkg::sat_add(bin_cur, 32'd1);
  assign ram_rd_en   = (data_start && bin_ok) || rd_issue;
  assign ram_rd_addr = (state == ST_REPORT) ? rd_idx : bin_raw[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      word_pos       <= '0;
      pkt_kind       <= mrfa_pkg::KIND_NONE;
      packet_count   <= '0;
      ack_count      <= '0;
      received_sum   <= '0;
      current_leader <= '0;
      bin_valid      <= '0;
      fb_pend        <= 1'b0;
      rep_kind       <= 1'b0;
      rd_idx         <= '0;
      rd_pend        <= 1'b0;
      rd_all         <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            if (s_tlast) begin
              word_pos <= '0;
              pkt_kind <= mrfa_pkg::KIND_NONE;
            end else begin
              pkt_kind <= kind_now;
              if (word_pos != POS_LIM) begin
                word_pos <= word_pos + POS_W'(1);
              end
            end
          end
          if (data_start) begin
            current_leader <= leader_new;
            packet_count   <= fb_hit ? 32'd0 : cnt_inc;
            upd_addr       <= bin_raw[IDX_W-1:0];
            fb_pend        <= fb_hit;
            rep_kind       <= 1'b0;
            rd_idx         <= '0;
            rd_all         <= 1'b0;
            if (bin_ok) begin
              state <= ST_BIN;
            end else if (fb_hit) begin
              state <= ST_REPORT;
            end
          end
          if (ack_word) begin
            if (sum_add) begin
              received_sum <= mrfa_pkg::sat_add(received_sum, payload_word);
            end
            if (s_tlast) begin
              ack_count <= mrfa_pkg::sat_add(ack_count, 32'd1);
              state     <= ST_CHECK;
            end
          end
        end
        ST_BIN: begin
          bin_valid[upd_addr] <= 1'b1;
          state <= fb_pend ? ST_REPORT : ST_IDLE;
        end
        ST_CHECK: begin
          rep_kind <= 1'b1;
          rd_idx   <= '0;
          rd_all   <= 1'b0;
          state    <= take_hit ? ST_REPORT : ST_IDLE;
        end
        ST_REPORT: begin
          if (rd_issue) begin
            rd_pend  <= 1'b1;
            rd_idx_q <= rd_idx;
            rd_vld   <= bin_valid[rd_idx];
            if (rd_idx == IDX_LAST) begin
              rd_all <= 1'b1;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          if (rd_pend) begin
            rd_pend  <= 1'b0;
            m_tvalid <= 1'b1;
            m_tuser  <= rep_kind;
            m_tlast  <= (rd_idx_q == IDX_LAST);
            if (rep_kind && (rd_idx_q == '0)) begin
              m_tdata <= mrfa_pkg::TAKEOVER_MARK;
            end else begin
              m_tdata <= rd_vld ? ram_rd_data : 32'd0;
            end
            if (rd_idx_q == IDX_LAST) begin
              bin_valid <= '0;
              state     <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sv/multicast_rate_feedback_agent.sv */
// ----------------------------------------------------------------------------
// multicast_rate_feedback_agent
// Snoops multicast packet words, keeps a rate histogram in a bin RAM and
// sends feedback reports of all bins or takeover reports led by a mark word.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                               | tuser | tlast
// s_*     | in  | dest_addr, dest_port, ttl, payload_word (88 b)   | -     | word_last
// m_*     | out | report_word (32 b)                               | kind  | report_last
// apb     | cfg | group_address, own_id, feedback/ack thr, ack_port at 4*i
//
// Words are taken while the sorter idles; a data packet's first word with a valid
// rate code is followed by a bin RAM read-modify-write, an ack's last word by a
// takeover check, each holding the input. A report holds it while the single
// bin RAM read port feeds one output register, one bin at a time; output stalls
// stretch it. Reset clears control state and counters, not the bin RAM; bins are
// marked empty by per-entry valid flops, so there is no clearing pass.
// ----------------------------------------------------------------------------
module multicast_rate_feedback_agent #(
  parameter int NUM_BINS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrfa_pkg::ADDR_W-1:0] paddr,
  input  logic [mrfa_pkg::DATA_W-1:0] pwdata,
  output logic [mrfa_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mrfa_pkg::IN_W-1:0]   s_tdata,  // dest_addr, dest_port, ttl, payload_word
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,  // report_word
  output logic                        m_tuser,  // report_kind
  output logic                        m_tlast
);

  localparam int IDX_W = $clog2(NUM_BINS);

  mrfa_pkg::cfg_t   cfg;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [31:0]      ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [31:0]      ram_rd_data;

  mrfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrfa_ram #(
    .WIDTH (32),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  mrfa_ctrl #(
    .NUM_BINS (NUM_BINS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

endmodule

/* sv/mrfa_chk.sv */
// ----------------------------------------------------------------------------
// mrfa_chk
// Port-level checks of the report stream, bound to the top level.
// ----------------------------------------------------------------------------
module mrfa_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("report transfer changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("report valid after reset");

  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input taken in the middle of a report");

  a_kind_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (m_tuser == $past(m_tuser)))
    else $error("report kind changed within a report");

endmodule

bind multicast_rate_feedback_agent mrfa_chk u_mrfa_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
